[design/buddy_block_allocator_unit_macros.svh]
`ifndef BUDDY_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

// Both macros expect signals named clk and rst_n in the module that uses them.

`define BBA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define BBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/bba_pkg.sv]
package bba_pkg;

    localparam int PAGE_COUNT = 16;
    localparam int PAGE_BYTES = 4096;
    localparam int NODE_COUNT = 31;

    localparam int NODE_W  = $clog2(NODE_COUNT);
    localparam int PAGE_W  = $clog2(PAGE_COUNT + 1);
    localparam int DEPTH_W = $clog2($clog2(NODE_COUNT + 1));

    localparam logic [PAGE_W-1:0] PAGES_ROOT  = PAGE_W'(PAGE_COUNT);
    localparam logic [31:0]       TOTAL_BYTES = 32'(PAGE_COUNT * PAGE_BYTES);
    localparam logic [31:0]       BASE_RESET  = 32'h0010_0000;

    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef enum logic [1:0] {
        BLK_NONE  = 2'd0,
        BLK_FREE  = 2'd1,
        BLK_SPLIT = 2'd2,
        BLK_OCC   = 2'd3
    } blk_state_t;

    typedef struct packed {
        logic              en;
        logic [NODE_W-1:0] addr;
        blk_state_t        data;
    } wr_req_t;

    typedef struct packed {
        logic [31:0] addr;
        logic        status;
    } result_t;

endpackage

[design/bba_state_store.sv]
module bba_state_store (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [bba_pkg::NODE_W-1:0] rd_addr,
    output bba_pkg::blk_state_t        rd_data,
    input  bba_pkg::wr_req_t           wr
);
    import bba_pkg::*;

    blk_state_t state_reg [NODE_COUNT];

    assign rd_data = state_reg[rd_addr];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NODE_COUNT; i++)
            begin
                state_reg[i] <= (i == 0) ? BLK_FREE : BLK_NONE;
            end
        end
        else if (wr.en)
        begin
            state_reg[wr.addr] <= wr.data;
        end
    end

endmodule

[design/bba_mul_unit.sv]
module bba_mul_unit (
    input  logic                       clk,
    input  logic [bba_pkg::PAGE_W-1:0] operand,
    output logic [31:0]                product_reg
);
    import bba_pkg::*;

    logic [31:0] product_next;

    assign product_next = 32'(operand) * 32'(PAGE_BYTES);

    always_ff @(posedge clk)
    begin
        product_reg <= product_next;
    end

endmodule

[design/bba_ctrl.sv]
`include "buddy_block_allocator_unit_macros.svh"

module bba_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       in_kind,
    input  logic [31:0]                in_size,
    input  logic [31:0]                in_addr,
    input  logic [31:0]                base_address,
    output bba_pkg::result_t           res,
    output logic                       res_valid,
    input  logic                       res_ready,
    output logic [bba_pkg::PAGE_W-1:0] mul_operand,
    input  logic [31:0]                mul_product,
    output logic [bba_pkg::NODE_W-1:0] rd_addr,
    input  bba_pkg::blk_state_t        rd_data,
    output bba_pkg::wr_req_t           wr
);
    import bba_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_A_MUL,
        S_A_EVAL,
        S_A_SPLIT_L,
        S_A_SPLIT_R,
        S_A_BACK,
        S_A_GRANT_MUL,
        S_A_GRANT,
        S_R_LO,
        S_R_HI,
        S_R_MID,
        S_R_EVAL,
        S_R_UP,
        S_R_SIB,
        S_R_MERGE_P,
        S_R_MERGE_N,
        S_R_MERGE_S,
        S_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [NODE_W-1:0]  node_reg, node_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [PAGE_W-1:0]  off_reg, off_next;
    logic [31:0]        size_reg, size_next;
    logic [31:0]        rel_reg, rel_next;
    logic [31:0]        lo_reg, lo_next;
    logic [31:0]        res_addr_reg, res_addr_next;
    logic               res_status_reg, res_status_next;

    logic [PAGE_W-1:0]  pages;
    logic [PAGE_W-1:0]  child_pages;
    logic [NODE_W+1:0]  left_wide;
    logic [NODE_W+1:0]  right_wide;
    logic [NODE_W-1:0]  left;
    logic [NODE_W-1:0]  right;
    logic [NODE_W-1:0]  parent;
    logic [NODE_W-1:0]  sib;
    logic               leaf;
    logic               too_big;
    logic [31:0]        in_rel;

    assign pages       = PAGES_ROOT >> depth_reg;
    assign child_pages = pages >> 1;
    assign left_wide   = {1'b0, node_reg, 1'b0} + (NODE_W + 2)'(1);
    assign right_wide  = {1'b0, node_reg, 1'b0} + (NODE_W + 2)'(2);
    assign left        = left_wide[NODE_W-1:0];
    assign right       = right_wide[NODE_W-1:0];
    assign parent      = (node_reg - NODE_W'(1)) >> 1;
    assign sib         = node_reg[0] ? node_reg + NODE_W'(1) : node_reg - NODE_W'(1);
    assign leaf        = (right_wide >= (NODE_W + 2)'(NODE_COUNT)) || (child_pages == '0);
    assign too_big     = leaf || (size_reg > mul_product);
    assign in_rel      = in_addr - base_address;

    assign in_ready   = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_DONE);
    assign res.addr   = res_addr_reg;
    assign res.status = res_status_reg;

    always_comb
    begin
        state_next      = state_reg;
        node_next       = node_reg;
        depth_next      = depth_reg;
        off_next        = off_reg;
        size_next       = size_reg;
        rel_next        = rel_reg;
        lo_next         = lo_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        mul_operand     = off_reg;
        rd_addr         = node_reg;
        wr.en           = 1'b0;
        wr.addr         = node_reg;
        wr.data         = BLK_NONE;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    size_next       = in_size;
                    rel_next        = in_rel;
                    node_next       = '0;
                    depth_next      = '0;
                    off_next        = '0;
                    res_addr_next   = '0;
                    res_status_next = STATUS_FAIL;
                    if (in_kind == KIND_ALLOC)
                    begin
                        state_next = (in_size > TOTAL_BYTES) ? S_DONE : S_A_MUL;
                    end
                    else
                    begin
                        state_next = (in_rel >= TOTAL_BYTES) ? S_DONE : S_R_LO;
                    end
                end
            end
            S_A_MUL:
            begin
                mul_operand = child_pages;
                state_next  = S_A_EVAL;
            end
            S_A_EVAL:
            begin
                if (rd_data == BLK_FREE)
                begin
                    wr.en = 1'b1;
                    if (too_big)
                    begin
                        wr.data    = BLK_OCC;
                        state_next = S_A_GRANT_MUL;
                    end
                    else
                    begin
                        wr.data    = BLK_SPLIT;
                        state_next = S_A_SPLIT_L;
                    end
                end
                else if (rd_data == BLK_SPLIT && !too_big)
                begin
                    node_next  = left;
                    depth_next = depth_reg + DEPTH_W'(1);
                    state_next = S_A_MUL;
                end
                else
                begin
                    state_next = S_A_BACK;
                end
            end
            S_A_SPLIT_L:
            begin
                wr.en      = 1'b1;
                wr.addr    = left;
                wr.data    = BLK_FREE;
                state_next = S_A_SPLIT_R;
            end
            S_A_SPLIT_R:
            begin
                wr.en      = 1'b1;
                wr.addr    = right;
                wr.data    = BLK_FREE;
                node_next  = left;
                depth_next = depth_reg + DEPTH_W'(1);
                state_next = S_A_MUL;
            end
            S_A_BACK:
            begin
                if (node_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else if (node_reg[0])
                begin
                    node_next  = node_reg + NODE_W'(1);
                    off_next   = off_reg + pages;
                    state_next = S_A_MUL;
                end
                else
                begin
                    node_next  = parent;
                    off_next   = off_reg - pages;
                    depth_next = depth_reg - DEPTH_W'(1);
                end
            end
            S_A_GRANT_MUL:
            begin
                mul_operand = off_reg;
                state_next  = S_A_GRANT;
            end
            S_A_GRANT:
            begin
                res_addr_next   = base_address + mul_product;
                res_status_next = STATUS_OK;
                state_next      = S_DONE;
            end
            S_R_LO:
            begin
                mul_operand = off_reg;
                state_next  = S_R_HI;
            end
            S_R_HI:
            begin
                mul_operand = off_reg + pages;
                lo_next     = mul_product;
                state_next  = S_R_MID;
            end
            S_R_MID:
            begin
                mul_operand = off_reg + child_pages;
                state_next  = (rel_reg >= mul_product) ? S_DONE : S_R_EVAL;
            end
            S_R_EVAL:
            begin
                if (rd_data == BLK_OCC)
                begin
                    if (rel_reg == lo_reg)
                    begin
                        wr.en      = 1'b1;
                        wr.data    = BLK_FREE;
                        state_next = S_R_UP;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else if (rd_data == BLK_SPLIT && !leaf)
                begin
                    if (rel_reg < mul_product)
                    begin
                        node_next = left;
                    end
                    else
                    begin
                        node_next = right;
                        off_next  = off_reg + child_pages;
                    end
                    depth_next = depth_reg + DEPTH_W'(1);
                    state_next = S_R_LO;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_R_UP:
            begin
                if (node_reg == '0 || rd_data != BLK_FREE)
                begin
                    res_status_next = STATUS_OK;
                    state_next      = S_DONE;
                end
                else
                begin
                    state_next = S_R_SIB;
                end
            end
            S_R_SIB:
            begin
                rd_addr = sib;
                if (rd_data == BLK_FREE)
                begin
                    state_next = S_R_MERGE_P;
                end
                else
                begin
                    res_status_next = STATUS_OK;
                    state_next      = S_DONE;
                end
            end
            S_R_MERGE_P:
            begin
                wr.en      = 1'b1;
                wr.addr    = parent;
                wr.data    = BLK_FREE;
                state_next = S_R_MERGE_N;
            end
            S_R_MERGE_N:
            begin
                wr.en      = 1'b1;
                wr.data    = BLK_NONE;
                state_next = S_R_MERGE_S;
            end
            S_R_MERGE_S:
            begin
                wr.en      = 1'b1;
                wr.addr    = sib;
                wr.data    = BLK_NONE;
                node_next  = parent;
                state_next = S_R_UP;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg       <= node_next;
        depth_reg      <= depth_next;
        off_reg        <= off_next;
        size_reg       <= size_next;
        rel_reg        <= rel_next;
        lo_reg         <= lo_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
    end

    `BBA_ASSERT_NOW(a_wr_in_tree, wr.en, wr.addr < NODE_W'(NODE_COUNT), "Tree write out of range")
    `BBA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "Ready after accept")
    `BBA_ASSERT_NOW(a_fail_zero_addr, res_valid && res.status == STATUS_FAIL, res.addr == '0,
                    "Failed result carries an address")

endmodule

[design/buddy_block_allocator_unit.sv]
// Buddy allocator over a region of PAGE_COUNT pages of PAGE_BYTES bytes starting at
// base_address. Each input word either allocates (the smallest fitting block found by a
// depth-first, left-first walk of the block tree) or releases the block whose base is the
// given address, merging free buddies upward. Each word yields one result word with the
// granted address and a status. The walk visits one tree node at a time through a single
// state store port and one shared page-to-byte multiplier: an allocate forms the child
// block size and evaluates each visited node, splits, backs out through parents and forms
// the granted address; a release forms the low, high and middle bounds at each level and
// evaluates there, then frees and merges. The input is not ready while a word is being
// worked; one finished result can wait in the output register while the next word is
// taken. The tree state is ready right after reset, and base_address must only be
// written while the block is idle.
module buddy_block_allocator_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // request_bytes [31:0], release_address [63:32]
    input  logic [0:0]  s_axis_tuser,  // kind [0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // granted_address [31:0]
    output logic [0:0]  m_axis_tuser,  // status [0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);
    import bba_pkg::*;

    logic [31:0]       base_address_reg;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg;
    result_t           res;
    logic              res_valid;
    logic              res_ready;
    logic [PAGE_W-1:0] mul_operand;
    logic [31:0]       mul_product;
    logic [NODE_W-1:0] rd_addr;
    blk_state_t        rd_data;
    wr_req_t           wr;

    assign cfg_ready     = 1'b1;
    assign res_ready     = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg.addr;
    assign m_axis_tuser  = out_reg.status;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_address_reg <= BASE_RESET;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                base_address_reg <= cfg_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    bba_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_kind      (s_axis_tuser[0]),
        .in_size      (s_axis_tdata[31:0]),
        .in_addr      (s_axis_tdata[63:32]),
        .base_address (base_address_reg),
        .res          (res),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .mul_operand  (mul_operand),
        .mul_product  (mul_product),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .wr           (wr)
    );

    bba_mul_unit u_mul (
        .clk         (clk),
        .operand     (mul_operand),
        .product_reg (mul_product)
    );

    bba_state_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr      (wr)
    );

endmodule

[dv/buddy_block_allocator_unit_checker.sv]
module buddy_block_allocator_unit_checker
    import bba_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic [0:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic [0:0]  m_axis_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [31:0] cfg_data,
    output int          mismatch_count,
    output int          pending_words
);
    timeunit 1ns;
    timeprecision 1ps;

    blk_state_t  tree [NODE_COUNT];
    logic [31:0] region_base;
    result_t     expected_q [$];
    result_t     want;
    result_t     next_result;

    initial mismatch_count = 0;

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] wanted);
        $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, wanted);
        mismatch_count++;
    endtask

    function automatic bit is_leaf_node(int node, int pages);
        return (2 * node + 2 >= NODE_COUNT) || (pages / 2 == 0);
    endfunction

    // Depth-first search, left before right. Only a free node changes the tree, and
    // descending from a free node always ends in a grant, so a stack walk matches the
    // recursive order exactly.
    function automatic result_t allocate_block(logic [31:0] nbytes);
        result_t res;
        int      node_q [$];
        int      pages_q [$];
        int      off_q [$];
        int      node;
        int      pages;
        int      pg_off;
        longint  half_bytes;
        res.addr = '0;
        res.status = STATUS_FAIL;
        if (longint'(nbytes) > longint'(PAGE_COUNT) * PAGE_BYTES)
            return res;
        node_q.push_back(0);
        pages_q.push_back(PAGE_COUNT);
        off_q.push_back(0);
        while (node_q.size() != 0)
        begin
            node = node_q.pop_back();
            pages = pages_q.pop_back();
            pg_off = off_q.pop_back();
            half_bytes = longint'(pages / 2) * PAGE_BYTES;
            if (tree[node] == BLK_FREE)
            begin
                while (!is_leaf_node(node, pages) && longint'(nbytes) <= half_bytes)
                begin
                    tree[node] = BLK_SPLIT;
                    tree[2 * node + 1] = BLK_FREE;
                    tree[2 * node + 2] = BLK_FREE;
                    node = 2 * node + 1;
                    pages = pages / 2;
                    half_bytes = longint'(pages / 2) * PAGE_BYTES;
                end
                tree[node] = BLK_OCC;
                res.addr = region_base + 32'(longint'(pg_off) * PAGE_BYTES);
                res.status = STATUS_OK;
                return res;
            end
            if (tree[node] == BLK_SPLIT && !is_leaf_node(node, pages) &&
                longint'(nbytes) <= half_bytes)
            begin
                node_q.push_back(2 * node + 2);
                pages_q.push_back(pages / 2);
                off_q.push_back(pg_off + pages / 2);
                node_q.push_back(2 * node + 1);
                pages_q.push_back(pages / 2);
                off_q.push_back(pg_off);
            end
        end
        return res;
    endfunction

    // The release path is unique, and every failure is found before the tree is touched.
    function automatic logic release_block(logic [31:0] addr);
        logic [31:0] rel;
        int          path_q [$];
        int          node;
        int          pages;
        int          pg_off;
        int          parent;
        bit          found;
        longint      lo;
        rel = addr - region_base;
        node = 0;
        pages = PAGE_COUNT;
        pg_off = 0;
        found = 1'b0;
        while (!found)
        begin
            lo = longint'(pg_off) * PAGE_BYTES;
            if (node >= NODE_COUNT || longint'(rel) < lo ||
                longint'(rel) >= lo + longint'(pages) * PAGE_BYTES)
                return STATUS_FAIL;
            if (tree[node] == BLK_OCC)
            begin
                if (longint'(rel) != lo)
                    return STATUS_FAIL;
                tree[node] = BLK_FREE;
                found = 1'b1;
            end
            else if (tree[node] != BLK_SPLIT || is_leaf_node(node, pages))
                return STATUS_FAIL;
            else
            begin
                path_q.push_back(node);
                if (longint'(rel) < longint'(pg_off + pages / 2) * PAGE_BYTES)
                    node = 2 * node + 1;
                else
                begin
                    node = 2 * node + 2;
                    pg_off = pg_off + pages / 2;
                end
                pages = pages / 2;
            end
        end
        while (path_q.size() != 0)
        begin
            parent = path_q.pop_back();
            if (tree[2 * parent + 1] == BLK_FREE && tree[2 * parent + 2] == BLK_FREE)
            begin
                tree[parent] = BLK_FREE;
                tree[2 * parent + 1] = BLK_NONE;
                tree[2 * parent + 2] = BLK_NONE;
            end
        end
        return STATUS_OK;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NODE_COUNT; i++)
                tree[i] = BLK_NONE;
            tree[0] = BLK_FREE;
            region_base = BASE_RESET;
            expected_q.delete();
            pending_words <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_q.size() == 0)
                    report_mismatch("result word with nothing expected", m_axis_tdata, '0);
                else
                begin
                    want = expected_q.pop_front();
                    if (m_axis_tdata !== want.addr)
                        report_mismatch("granted_address", m_axis_tdata, want.addr);
                    if (m_axis_tuser[0] !== want.status)
                        report_mismatch("status", 32'(m_axis_tuser[0]), 32'(want.status));
                end
            end
            if (cfg_valid && cfg_ready)
                region_base = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser[0] == KIND_ALLOC)
                    next_result = allocate_block(s_axis_tdata[31:0]);
                else
                begin
                    next_result.addr = '0;
                    next_result.status = release_block(s_axis_tdata[63:32]);
                end
                expected_q.push_back(next_result);
            end
            pending_words <= expected_q.size();
        end
    end

endmodule

[dv/buddy_block_allocator_unit_tb.sv]
module buddy_block_allocator_unit_tb;
    import bba_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES  = 2 * NODE_COUNT + 40;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_COUNT    = 6;
    localparam int PHASE_WORDS    = 80;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic [0:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;

    int          mismatch_count;
    int          pending_words;

    int          burst_left = 0;
    int          rx_mode = 0;
    int          rx_left = 0;
    int          quiet_cycles = 0;
    logic [31:0] cur_base = BASE_RESET;
    logic        kinds_sent [$];
    logic [31:0] live_addrs [$];
    logic [31:0] freed_addrs [$];

    buddy_block_allocator_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    buddy_block_allocator_unit_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending_words  (pending_words)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(20, 200);
        end
        else
            rx_left <= rx_left - 1;
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2: m_axis_tready <= 1'($urandom_range(0, 1));
            default: m_axis_tready <= ((rx_left % 16) < 3);
        endcase
    end

    // Granted addresses are collected on the falling edge ahead of the rising edge that takes them.
    always @(negedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready && kinds_sent.size() != 0)
        begin
            if (kinds_sent.pop_front() == KIND_ALLOC && m_axis_tuser[0] == STATUS_OK)
                live_addrs.push_back(m_axis_tdata);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_word(logic kind, logic [31:0] nbytes, logic [31:0] addr);
        s_axis_tdata <= {addr, nbytes};
        s_axis_tuser <= kind;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        kinds_sent.push_back(kind);
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 24))
                @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 8);
        end
        else
            burst_left--;
    endtask

    task automatic wait_until_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_words != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic send_random();
        int          choice;
        int          idx;
        int          pages;
        int          release_pct;
        logic [31:0] nbytes;
        logic [31:0] addr;
        release_pct = 30 + 8 * live_addrs.size();
        if (release_pct > 85)
            release_pct = 85;
        if ($urandom_range(0, 99) < release_pct)
        begin
            choice = $urandom_range(0, 9);
            if (choice < 6 && live_addrs.size() != 0)
            begin
                idx = $urandom_range(0, live_addrs.size() - 1);
                addr = live_addrs[idx];
                live_addrs.delete(idx);
                freed_addrs.push_back(addr);
                if (freed_addrs.size() > 8)
                    void'(freed_addrs.pop_front());
            end
            else if (choice == 6 && freed_addrs.size() != 0)
                addr = freed_addrs[$urandom_range(0, freed_addrs.size() - 1)];
            else if (choice == 7 && live_addrs.size() != 0)
                addr = live_addrs[$urandom_range(0, live_addrs.size() - 1)] +
                       $urandom_range(1, 2 * PAGE_BYTES);
            else if (choice == 8)
                addr = cur_base + PAGE_BYTES * $urandom_range(0, PAGE_COUNT);
            else
                addr = $urandom();
            send_word(KIND_RELEASE, $urandom(), addr);
        end
        else
        begin
            choice = $urandom_range(0, 19);
            pages = $urandom_range(1, $urandom_range(1, PAGE_COUNT));
            if (choice == 0)
                nbytes = '0;
            else if (choice == 1)
                nbytes = $urandom();
            else if (choice == 2)
                nbytes = PAGE_COUNT * PAGE_BYTES + $urandom_range(0, 1);
            else if (choice < 6)
                nbytes = pages * PAGE_BYTES + $urandom_range(0, 1);
            else
                nbytes = pages * PAGE_BYTES - $urandom_range(0, PAGE_BYTES - 1);
            send_word(KIND_ALLOC, nbytes, $urandom());
        end
    endtask

    initial
    begin
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(KIND_ALLOC, 32'd0, 32'hFFFF_FFFF);
        send_word(KIND_ALLOC, 32'd1, 32'd0);
        send_word(KIND_ALLOC, PAGE_BYTES, 32'hA5A5_5A5A);
        send_word(KIND_ALLOC, PAGE_BYTES + 1, 32'd0);
        send_word(KIND_ALLOC, PAGE_COUNT * PAGE_BYTES, 32'd0);
        send_word(KIND_ALLOC, PAGE_COUNT * PAGE_BYTES + 1, 32'd0);
        send_word(KIND_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(KIND_RELEASE, 32'd0, BASE_RESET + 1);
        send_word(KIND_RELEASE, 32'd0, BASE_RESET - PAGE_BYTES);
        send_word(KIND_RELEASE, 32'd0, BASE_RESET + 3 * PAGE_BYTES);
        send_word(KIND_RELEASE, 32'd0, BASE_RESET + PAGE_COUNT * PAGE_BYTES);
        send_word(KIND_RELEASE, 32'd0, BASE_RESET + (PAGE_COUNT / 2) * PAGE_BYTES);
        send_word(KIND_RELEASE, 32'h5A5A_A5A5, BASE_RESET + PAGE_BYTES);
        send_word(KIND_RELEASE, 32'd0, BASE_RESET + PAGE_BYTES);
        send_word(KIND_RELEASE, 32'd0, BASE_RESET);
        send_word(KIND_RELEASE, 32'd0, BASE_RESET + 2 * PAGE_BYTES);
        send_word(KIND_RELEASE, 32'd0, BASE_RESET + 4 * PAGE_BYTES);
        send_word(KIND_ALLOC, PAGE_COUNT * PAGE_BYTES, 32'd0);
        send_word(KIND_ALLOC, 32'd0, 32'd0);
        send_word(KIND_RELEASE, 32'd0, BASE_RESET);
        send_word(KIND_ALLOC, (PAGE_COUNT / 2) * PAGE_BYTES, 32'd0);
        send_word(KIND_ALLOC, (PAGE_COUNT / 2) * PAGE_BYTES + 1, 32'd0);
        send_word(KIND_RELEASE, 32'hFFFF_FFFF, BASE_RESET + (PAGE_COUNT / 2) * PAGE_BYTES);
        send_word(KIND_RELEASE, 32'hFFFF_FFFF, BASE_RESET);
        wait_until_idle();
        live_addrs.delete();
        freed_addrs.delete();

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0: cfg_data <= 32'h0000_0000;
                1: cfg_data <= 32'hFFFF_FFFF;
                2: cfg_data <= 32'hFFFF_8000;
                3: cfg_data <= $urandom() & ~32'(PAGE_BYTES - 1);
                4: cfg_data <= $urandom();
                default: cfg_data <= BASE_RESET;
            endcase
            cfg_valid <= 1'b1;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            cfg_valid <= 1'b0;
            foreach (live_addrs[i])
                live_addrs[i] = live_addrs[i] - cur_base + cfg_data;
            foreach (freed_addrs[i])
                freed_addrs[i] = freed_addrs[i] - cur_base + cfg_data;
            cur_base = cfg_data;
            @(posedge clk);
            repeat (PHASE_WORDS)
                send_random();
            wait_until_idle();
        end

        if (mismatch_count == 0 && pending_words == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/bba_pkg.sv
design/bba_state_store.sv
design/bba_mul_unit.sv
design/bba_ctrl.sv
design/buddy_block_allocator_unit.sv
dv/buddy_block_allocator_unit_checker.sv
dv/buddy_block_allocator_unit_tb.sv
